### src/cdra_pkg.sv
// ----------------------------------------------------------------------------
// cdra_pkg
// Types and constants shared by the chunked range allocator and its cells.
// ----------------------------------------------------------------------------
package cdra_pkg;

    localparam int NUM_CHUNKS      = 16;
    localparam int SLOTS_PER_CHUNK = 256;
    localparam int MAX_RANGES      = 16;

    localparam int CHUNK_W = 4;
    localparam int OFF_W   = 8;
    localparam int SLOT_W  = CHUNK_W + OFF_W;
    localparam int RANGE_W = OFF_W + 1;
    localparam int RIDX_W  = 4;
    localparam int CNT_W   = 5;
    localparam int FILL_W  = 5;
    localparam int USED_W  = 13;
    localparam int SIZE_W  = 9;
    localparam int ADDR_W  = 48;
    localparam int PROD_W  = SLOT_W + SIZE_W;

    typedef logic [RANGE_W-1:0] range_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        cell_op_t           op;
        logic [RIDX_W-1:0]  pos;
        range_t             new_first;
        range_t             new_limit;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SCAN,
        S_MUL,
        S_FIN
    } state_t;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_CPU  = 2'd1;
    localparam logic [1:0] REG_GPU  = 2'd2;

endpackage

### src/chunked_descriptor_range_allocator.sv
// Steps from accept to result beat: allocate goes through take, multiply and finish;
// free scans the range positions in order until it finds its place, then finishes;
// nothing-free allocate and foreign-slot free go straight to finish.
// Throughput: one command at a time; the next beat is taken at the edge the result leaves.
// Reset (aresetn low, synchronous): every chunk holds one full range, all chunks
// queued in order, count zero, stride 32 and both bases zero.
// ----------------------------------------------------------------------------
// chunked_descriptor_range_allocator
// Slot allocator over chunks with ordered free-range lists held in a cell chain.
// ----------------------------------------------------------------------------
module chunked_descriptor_range_allocator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [47:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,   // cmd
    input  logic [15:0]   s_tdata,   // slot[11:0], chunk[15:12]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [1:0]    m_tuser,   // status
    output logic [127:0]  m_tdata    // got_chunk, got_slot, cpu_address, gpu_address,
                                     // allocated_count, zero pad
);
    import cdra_pkg::*;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [1:0]          status_reg, status_next;
    logic [SLOT_W-1:0]   gslot_reg, gslot_next;
    logic [CHUNK_W-1:0]  gchunk_reg, gchunk_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]    count_reg [NUM_CHUNKS];
    logic [CNT_W-1:0]    count_next [NUM_CHUNKS];
    logic [CHUNK_W-1:0]  queue_reg [NUM_CHUNKS];
    logic [CHUNK_W-1:0]  queue_next [NUM_CHUNKS];
    logic [CHUNK_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   cpu_base_reg, gpu_base_reg;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_user_reg, m_user_next;
    logic [127:0]        m_data_reg, m_data_next;

    cell_ctl_t ctl;
    range_t    cf [MAX_RANGES];
    range_t    cl [MAX_RANGES];

    genvar k;
    generate
        for (k = 0; k < MAX_RANGES; k++) begin : g_cell
            cdra_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .idx         (RIDX_W'(k)),
                .head        (k == 0),
                .ctl         (ctl),
                .left_first  ((k == 0) ? range_t'(0) : cf[(k == 0) ? 0 : k-1]),
                .left_limit  ((k == 0) ? range_t'(0) : cl[(k == 0) ? 0 : k-1]),
                .right_first ((k == MAX_RANGES-1) ? range_t'(0)
                              : cf[(k == MAX_RANGES-1) ? k : k+1]),
                .right_limit ((k == MAX_RANGES-1) ? range_t'(0)
                              : cl[(k == MAX_RANGES-1) ? k : k+1]),
                .rd_first    (cf[k]),
                .rd_limit    (cl[k])
            );
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    logic [OFF_W-1:0]  off;
    range_t            off9, off_inc, f_i, l_i, f_inc;
    logic [CNT_W-1:0]  n;
    logic [ADDR_W-1:0] cpu_sum, gpu_sum;

    assign off     = slot_reg[OFF_W-1:0];
    assign off9    = {1'b0, off};
    assign off_inc = off9 + range_t'(1);
    assign f_i     = cf[idx_reg[RIDX_W-1:0]];
    assign l_i     = cl[idx_reg[RIDX_W-1:0]];
    assign f_inc   = cf[0] + range_t'(1);
    assign n       = count_reg[chunk_reg];
    assign cpu_sum = cpu_base_reg + ADDR_W'(prod_reg);
    assign gpu_sum = gpu_base_reg + ADDR_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= SIZE_W'(32);
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SIZE: size_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_CPU:  cpu_base_reg <= cfg_wdata;
                REG_GPU:  gpu_base_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            chunk_reg   <= '0;
            used_reg    <= '0;
            head_reg    <= '0;
            fill_reg    <= FILL_W'(NUM_CHUNKS);
            m_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_CHUNKS; j++) begin
                count_reg[j] <= CNT_W'(1);
                queue_reg[j] <= CHUNK_W'(j);
            end
        end else begin
            state_reg   <= state_next;
            chunk_reg   <= chunk_next;
            used_reg    <= used_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            queue_reg   <= queue_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        gslot_reg  <= gslot_next;
        gchunk_reg <= gchunk_next;
        prod_reg   <= prod_next;
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        chunk_next   = chunk_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        gslot_next   = gslot_reg;
        gchunk_next  = gchunk_reg;
        prod_next    = prod_reg;
        used_next    = used_reg;
        count_next   = count_reg;
        queue_next   = queue_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        ctl.chunk     = chunk_reg;
        ctl.op        = CELL_HOLD;
        ctl.pos       = '0;
        ctl.new_first = off9;
        ctl.new_limit = off_inc;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd_next    = s_tuser;
                    slot_next   = s_tdata[SLOT_W-1:0];
                    status_next = ST_OK;
                    gslot_next  = '0;
                    gchunk_next = '0;
                    idx_next    = '0;
                    if (s_tuser == CMD_ALLOC) begin
                        chunk_next = queue_reg[head_reg];
                        if (fill_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end else begin
                            state_next = S_TAKE;
                        end
                    end else begin
                        chunk_next = s_tdata[15:12];
                        // slot outside its claimed chunk is ignored
                        if (s_tdata[SLOT_W-1:OFF_W] != s_tdata[15:12])
                            state_next = S_FIN;
                        else
                            state_next = S_SCAN;
                    end
                end
            end
            S_TAKE: begin
                gslot_next  = {chunk_reg, cf[0][OFF_W-1:0]};
                gchunk_next = chunk_reg;
                used_next   = used_reg + USED_W'(1);
                if (f_inc >= cl[0]) begin
                    ctl.op = CELL_REMOVE;
                    count_next[chunk_reg] = n - CNT_W'(1);
                    if (n == CNT_W'(1)) begin
                        head_next = head_reg + CHUNK_W'(1);
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end else begin
                    ctl.op        = CELL_WRITE;
                    ctl.new_first = f_inc;
                    ctl.new_limit = cl[0];
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = PROD_W'(gslot_reg) * PROD_W'(size_reg);
                state_next = S_FIN;
            end
            S_SCAN: begin
                if (idx_reg == n) begin
                    if (n >= CNT_W'(MAX_RANGES)) begin
                        status_next = ST_FULL;
                    end else begin
                        ctl.op  = CELL_INSERT;
                        ctl.pos = idx_reg[RIDX_W-1:0];
                        count_next[chunk_reg] = n + CNT_W'(1);
                        used_next = used_reg - USED_W'(1);
                        if (n == '0 && fill_reg < FILL_W'(NUM_CHUNKS)) begin
                            queue_next[head_reg + fill_reg[CHUNK_W-1:0]] = chunk_reg;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                    state_next = S_FIN;
                end else if (f_i == off_inc) begin
                    ctl.op        = CELL_WRITE;
                    ctl.pos       = idx_reg[RIDX_W-1:0];
                    ctl.new_first = off9;
                    ctl.new_limit = l_i;
                    used_next     = used_reg - USED_W'(1);
                    state_next    = S_FIN;
                end else if (l_i == off9) begin
                    ctl.op        = CELL_WRITE;
                    ctl.pos       = idx_reg[RIDX_W-1:0];
                    ctl.new_first = f_i;
                    ctl.new_limit = l_i + range_t'(1);
                    used_next     = used_reg - USED_W'(1);
                    state_next    = S_FIN;
                end else if (off9 >= f_i && off9 < l_i) begin
                    state_next = S_FIN;      // double free
                end else if (f_i > off9) begin
                    if (n >= CNT_W'(MAX_RANGES)) begin
                        status_next = ST_FULL;
                    end else begin
                        ctl.op  = CELL_INSERT;
                        ctl.pos = idx_reg[RIDX_W-1:0];
                        count_next[chunk_reg] = n + CNT_W'(1);
                        used_next = used_reg - USED_W'(1);
                    end
                    state_next = S_FIN;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_FIN: begin
                m_valid_next = 1'b1;
                m_user_next  = status_reg;
                m_data_next  = '0;
                m_data_next[3:0]   = gchunk_reg;
                m_data_next[15:4]  = gslot_reg;
                if (cmd_reg == CMD_ALLOC && status_reg == ST_OK) begin
                    m_data_next[63:16]  = cpu_sum;
                    m_data_next[111:64] = gpu_sum;
                end
                m_data_next[124:112] = used_reg;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_W'(NUM_CHUNKS * SLOTS_PER_CHUNK))
        else $error("allocated count above slot total");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(NUM_CHUNKS))
        else $error("chunk queue overfilled");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted beat not processed");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n <= CNT_W'(MAX_RANGES))
        else $error("range list count overflow");
`endif

endmodule

### src/cdra_cell.sv
// ----------------------------------------------------------------------------
// cdra_cell
// One range position of every chunk's list; shifts with its neighbors.
// ----------------------------------------------------------------------------
module cdra_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [3:0]         idx,
    input  logic               head,
    input  cdra_pkg::cell_ctl_t ctl,
    input  cdra_pkg::range_t   left_first,
    input  cdra_pkg::range_t   left_limit,
    input  cdra_pkg::range_t   right_first,
    input  cdra_pkg::range_t   right_limit,
    output cdra_pkg::range_t   rd_first,
    output cdra_pkg::range_t   rd_limit
);
    import cdra_pkg::*;

    range_t first_reg [NUM_CHUNKS];
    range_t limit_reg [NUM_CHUNKS];

    assign rd_first = first_reg[ctl.chunk];
    assign rd_limit = limit_reg[ctl.chunk];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_CHUNKS; j++) begin
                first_reg[j] <= '0;
                limit_reg[j] <= head ? RANGE_W'(SLOTS_PER_CHUNK) : '0;
            end
        end else begin
            case (ctl.op)
                CELL_WRITE: begin
                    if (idx == ctl.pos) begin
                        first_reg[ctl.chunk] <= ctl.new_first;
                        limit_reg[ctl.chunk] <= ctl.new_limit;
                    end
                end
                CELL_INSERT: begin
                    if (idx == ctl.pos) begin
                        first_reg[ctl.chunk] <= ctl.new_first;
                        limit_reg[ctl.chunk] <= ctl.new_limit;
                    end else if (idx > ctl.pos) begin
                        first_reg[ctl.chunk] <= left_first;
                        limit_reg[ctl.chunk] <= left_limit;
                    end
                end
                CELL_REMOVE: begin
                    if (idx >= ctl.pos) begin
                        first_reg[ctl.chunk] <= right_first;
                        limit_reg[ctl.chunk] <= right_limit;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
